[rtl/agm_pkg.sv]
// ----------------------------------------------------------------------------
// agm_pkg: shared types and constants for the gain stage and level meter
// Holds field widths, the frame cap and the front-to-back job record.
// ----------------------------------------------------------------------------
package agm_pkg;

  localparam int MAX_FRAME_SAMPLES = 4096;
  localparam int COUNT_CAP = (MAX_FRAME_SAMPLES < 8191) ? MAX_FRAME_SAMPLES : 8191;
  localparam logic [15:0] GAIN_RESET = 16'd4096;
  localparam logic [20:0] LOG_SCALE = 21'd1972830;
  localparam logic signed [10:0] LEVEL_FLOOR = -11'sd600;

  typedef struct packed {
    logic signed [15:0] scaled;
    logic               last;
    logic [42:0]        sum;
    logic [12:0]        count;
  } agm_job_t;

  typedef struct packed {
    logic signed [15:0] scaled_sample;
    logic               level_valid;
    logic signed [10:0] level_tenth_db;
  } agm_res_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_NORM, ST_SQR, ST_MUL, ST_OUT
  } agm_state_t;

endpackage

[rtl/agm_if.sv]
// ----------------------------------------------------------------------------
// agm_if: valid/ready channel
// Generic handshake channel carrying one payload item.
// ----------------------------------------------------------------------------
interface agm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               frame_last;
  modport source (output valid, output sample, output frame_last, input ready);
  modport sink (input valid, input sample, input frame_last, output ready);
endinterface

interface agm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] scaled_sample;
  logic               level_valid;
  logic signed [10:0] level_tenth_db;
  modport source (output valid, output scaled_sample, output level_valid,
                  output level_tenth_db, input ready);
  modport sink (input valid, input scaled_sample, input level_valid,
                input level_tenth_db, output ready);
endinterface

interface agm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/audio_gain_rms_level_meter.sv]
// ----------------------------------------------------------------------------
// audio_gain_rms_level_meter: gain stage with frame rms meter
// Scales samples by a Q4.12 gain and reports frame levels in tenths of a dB.
// ----------------------------------------------------------------------------
// channel  dir  fields                                         handshake
// in_ch    in   sample, frame_last                             valid/ready
// out_ch   out  scaled_sample, level_valid, level_tenth_db     valid/ready
// cfg_ch   in   data (gain_q12)                                valid/ready
//
// a plain sample's result is registered in turn by the gain stage, the
// one-entry queue and the back part
// a frame's last sample's result takes, in the back part, 59 divide steps,
// normalizing shifts, 16 squaring rounds and one multiply
// synchronous active-low reset, gain returns to unity
// output stalls hold the back part; stage and queue let the front take two more
module audio_gain_rms_level_meter (
  input logic clk,
  input logic rst_n,
  agm_in_if.sink    in_ch,
  agm_out_if.source out_ch,
  agm_cfg_if.sink   cfg_ch
);
  import agm_pkg::*;

  logic [15:0] gain_r;
  agm_job_t job, q_job_r;
  logic q_valid_r, q_ready, f_valid, push, job_ready, res_valid;
  agm_res_t res;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) gain_r <= GAIN_RESET;
    else if (cfg_ch.valid) gain_r <= cfg_ch.data;
  end

  agm_front u_front (
    .clk, .rst_n, .gain(gain_r), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .sample(in_ch.sample), .frame_last(in_ch.frame_last),
    .job_valid(f_valid), .job_ready(q_ready), .job
  );

  // single-entry queue between front and back
  assign q_ready = !q_valid_r;
  assign push = f_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) q_valid_r <= 1'b0;
    else if (push) q_valid_r <= 1'b1;
    else if (job_ready) q_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) if (push) q_job_r <= job;

  agm_back u_back (
    .clk, .rst_n, .job_valid(q_valid_r), .job(q_job_r), .job_ready,
    .res_valid, .res_ready(out_ch.ready), .res
  );

  assign out_ch.valid          = res_valid;
  assign out_ch.scaled_sample  = res.scaled_sample;
  assign out_ch.level_valid    = res.level_valid;
  assign out_ch.level_tenth_db = res.level_tenth_db;
endmodule

[rtl/agm_front.sv]
// ----------------------------------------------------------------------------
// agm_front: gain, saturation and square accumulation
// Scales each item into a stage register, then squares and accumulates it
// and snapshots the frame sum at the frame's last sample.
// ----------------------------------------------------------------------------
module agm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [15:0]        gain,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] sample,
  input  logic               frame_last,
  output logic               job_valid,
  input  logic               job_ready,
  output agm_pkg::agm_job_t  job
);
  import agm_pkg::*;

  logic signed [32:0] prod;
  logic signed [20:0] rnd;
  logic signed [15:0] sat;
  logic signed [15:0] sat_r;
  logic               last_r, stg_vld_r;
  logic               fire, push;
  logic [31:0]        sq;
  logic [42:0]        sum_r, sum_nxt, sum_add;
  logic [12:0]        cnt_r, cnt_nxt, cnt_add;
  logic               take;

  // stage register frees up when its item moves on
  assign push      = stg_vld_r && job_ready;
  assign in_ready  = !stg_vld_r || push;
  assign fire      = in_valid && in_ready;
  assign job_valid = stg_vld_r;

  assign prod = sample * $signed({1'b0, gain});
  assign rnd  = 21'((prod + 33'sd2048) >>> 12);
  always_comb begin
    if (rnd > 21'sd32767) sat = 16'sd32767;
    else if (rnd < -21'sd32768) sat = -16'sd32768;
    else sat = rnd[15:0];
  end

  // square and accumulate the staged item
  assign sq = 32'(32'(sat_r) * 32'(sat_r));
  assign take = cnt_r < 13'(COUNT_CAP);
  assign sum_add = take ? sum_r + {11'd0, sq} : sum_r;
  assign cnt_add = take ? cnt_r + 13'd1 : cnt_r;
  assign sum_nxt = last_r ? '0 : sum_add;
  assign cnt_nxt = last_r ? '0 : cnt_add;

  always_comb begin
    job.scaled = sat_r;
    job.last   = last_r;
    job.sum    = sum_add;
    job.count  = cnt_add;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      sum_r     <= '0;
      cnt_r     <= '0;
    end else begin
      if (fire) stg_vld_r <= 1'b1;
      else if (push) stg_vld_r <= 1'b0;
      if (push) begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      sat_r  <= sat;
      last_r <= frame_last;
    end
  end
endmodule

[rtl/agm_back.sv]
// ----------------------------------------------------------------------------
// agm_back: frame level engine
// Divides, normalizes, takes log2 by squaring and scales to tenths of a dB.
// ----------------------------------------------------------------------------
module agm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  input  agm_pkg::agm_job_t job,
  output logic              job_ready,
  output logic              res_valid,
  input  logic              res_ready,
  output agm_pkg::agm_res_t res
);
  import agm_pkg::*;

  agm_state_t st_r, st_nxt;
  logic [58:0] q_r;
  logic [12:0] rem_r, den_r;
  logic [5:0]  step_r;
  logic [5:0]  e_r;
  logic [31:0] m_r;
  logic [15:0] frac_r;
  logic signed [15:0] scaled_r;
  logic        last_r;
  logic signed [10:0] lvl_r;
  logic [13:0] trial;
  logic [63:0] msq;
  logic [33:0] msh;
  logic [22:0] neg_lg;
  logic [43:0] mag;
  logic        zero_q;

  assign trial = {rem_r, q_r[58]};
  assign msq = {32'd0, m_r} * {32'd0, m_r};
  assign msh = msq[63:30];
  assign neg_lg = 23'({6'd46, 16'd0} - {1'b0, e_r, frac_r});
  assign mag = ({21'd0, neg_lg} * {23'd0, LOG_SCALE} + 44'h0_8000_0000) >> 32;
  assign zero_q = (q_r == '0);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (job_valid) st_nxt = job.last ? ST_DIV : ST_OUT;
      ST_DIV:  if (step_r == 6'd58) st_nxt = ST_NORM;
      ST_NORM: if (zero_q || (q_r[58:31] == '0 && q_r[30])) st_nxt = zero_q ? ST_OUT : ST_SQR;
      ST_SQR:  if (step_r == 6'd15) st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_OUT;
      ST_OUT:  if (res_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (st_r == ST_IDLE);
    res_valid = (st_r == ST_OUT);
    res.scaled_sample  = scaled_r;
    res.level_valid    = last_r;
    res.level_tenth_db = last_r ? lvl_r : 11'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: if (job_valid) begin
        scaled_r <= job.scaled;
        last_r   <= job.last;
        q_r      <= {job.sum, 16'd0};
        den_r    <= job.count;
        rem_r    <= '0;
        step_r   <= '0;
        lvl_r    <= LEVEL_FLOOR;
      end
      ST_DIV: begin
        // restoring divide, one quotient bit a cycle
        if (trial >= {1'b0, den_r} && den_r != '0) begin
          rem_r <= 13'(trial - {1'b0, den_r});
          q_r   <= {q_r[57:0], 1'b1};
        end else begin
          rem_r <= trial[12:0];
          q_r   <= {q_r[57:0], 1'b0};
        end
        step_r <= step_r + 6'd1;
        if (step_r == 6'd58) e_r <= 6'd30;
      end
      ST_NORM: begin
        // shift one place a cycle toward [2^30, 2^31)
        if (!zero_q) begin
          if (q_r[58:31] != '0) begin
            q_r <= q_r >> 1;
            e_r <= e_r + 6'd1;
          end else if (!q_r[30]) begin
            q_r <= q_r << 1;
            e_r <= e_r - 6'd1;
          end
        end
        m_r    <= q_r[31:0];
        step_r <= '0;
        frac_r <= '0;
      end
      ST_SQR: begin
        if (msh[31]) begin
          m_r    <= msh[32:1];
          frac_r <= {frac_r[14:0], 1'b1};
        end else begin
          m_r    <= msh[31:0];
          frac_r <= {frac_r[14:0], 1'b0};
        end
        step_r <= step_r + 6'd1;
      end
      ST_MUL: begin
        if (mag > 44'd600) lvl_r <= LEVEL_FLOOR;
        else lvl_r <= -$signed({1'b0, mag[9:0]});
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed while stalled");
  a_lvl_rng: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res.level_tenth_db <= 11'sd0 && res.level_tenth_db >= LEVEL_FLOOR)
    else $error("level out of range");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !job_ready)
    else $error("back part idle with result pending");
endmodule
